[rtl/core/cbd_pkg.sv]
// Types, codes and helper functions shared by the chunked body decoder files.
`timescale 1ns / 1ps
package cbd_pkg;

  localparam logic [31:0] MaxChunkSizeReset = 32'd1048576;
  localparam logic [31:0] SizeAllOnes       = 32'hFFFF_FFFF;

  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  localparam logic [1:0] FuncData    = 2'd0;
  localparam logic [1:0] FuncEnd     = 2'd1;
  localparam logic [1:0] FuncRestart = 2'd2;

  typedef enum logic [2:0] {
    KIND_CONSUMED  = 3'd0,
    KIND_BODY      = 3'd1,
    KIND_COMPLETE  = 3'd2,
    KIND_BAD       = 3'd3,
    KIND_TOO_LARGE = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    PH_SIZE_FIRST = 3'd0,
    PH_SIZE_MORE  = 3'd1,
    PH_SIZE_LF    = 3'd2,
    PH_DATA       = 3'd3,
    PH_SKIP_LINE  = 3'd4,
    PH_LAST_LINE  = 3'd5,
    PH_FINISHED   = 3'd6
  } phase_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  body_byte;
    logic [31:0] body_length;
  } out_item_t;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] size_or_remaining;
    logic        size_overflow;
    logic [31:0] body_total;
  } dec_state_t;

  // Returns whether the byte is a hex digit of either case, and its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      res = {1'b1, c[3:0] + 4'd9};
    end
    return res;
  endfunction

endpackage

[rtl/core/cbd_step.sv]
// Next-state and result logic of the chunked body decoder for one beat.
`timescale 1ns / 1ps
module cbd_step
  import cbd_pkg::*;
(
  input  dec_state_t  state_i,
  input  in_item_t    item_i,
  input  logic [31:0] max_chunk_size_i,
  output dec_state_t  state_o,
  output out_item_t   result_o
);

  logic [4:0]  hex;
  logic        acc_sat;
  logic [31:0] acc_value;
  logic        too_large;
  phase_e      line_done_phase;
  kind_e       line_done_kind;
  kind_e       kind;
  logic [7:0]  byte_out;

  assign hex = hex_value(item_i.data_byte);

  // Shifting in one more digit overflows exactly when the top nibble is in use.
  assign acc_sat   = state_i.size_overflow || (|state_i.size_or_remaining[31:28]);
  assign acc_value = acc_sat ? SizeAllOnes
                             : {state_i.size_or_remaining[27:0], hex[3:0]};

  assign too_large = state_i.size_overflow || (state_i.size_or_remaining > max_chunk_size_i);

  always_comb begin
    if (too_large) begin
      line_done_phase = PH_FINISHED;
      line_done_kind  = KIND_TOO_LARGE;
    end else begin
      line_done_phase = (state_i.size_or_remaining == '0) ? PH_LAST_LINE : PH_DATA;
      line_done_kind  = KIND_CONSUMED;
    end
  end

  always_comb begin
    state_o  = state_i;
    kind     = KIND_CONSUMED;
    byte_out = 8'd0;
    if (item_i.func == FuncRestart) begin
      state_o.phase             = PH_SIZE_FIRST;
      state_o.size_or_remaining = '0;
      state_o.size_overflow     = 1'b0;
      state_o.body_total        = '0;
    end else if (item_i.func == FuncEnd) begin
      if (state_i.phase != PH_FINISHED) begin
        state_o.phase = PH_FINISHED;
        kind          = KIND_BAD;
      end
    end else if (item_i.func == FuncData) begin
      case (state_i.phase)
        PH_SIZE_FIRST: begin
          if (!hex[4]) begin
            state_o.phase = PH_FINISHED;
            kind          = KIND_BAD;
          end else begin
            state_o.size_or_remaining = acc_value;
            state_o.size_overflow     = acc_sat;
            state_o.phase             = PH_SIZE_MORE;
          end
        end
        PH_SIZE_MORE: begin
          if (hex[4]) begin
            state_o.size_or_remaining = acc_value;
            state_o.size_overflow     = acc_sat;
          end else if (item_i.data_byte == CharCr) begin
            state_o.phase = PH_SIZE_LF;
          end else if (item_i.data_byte == CharLf) begin
            state_o.phase = line_done_phase;
            kind          = line_done_kind;
          end else begin
            state_o.phase = PH_FINISHED;
            kind          = KIND_BAD;
          end
        end
        PH_SIZE_LF: begin
          if (item_i.data_byte == CharLf) begin
            state_o.phase = line_done_phase;
            kind          = line_done_kind;
          end else begin
            state_o.phase = PH_FINISHED;
            kind          = KIND_BAD;
          end
        end
        PH_DATA: begin
          kind     = KIND_BODY;
          byte_out = item_i.data_byte;
          if (state_i.body_total != SizeAllOnes) begin
            state_o.body_total = state_i.body_total + 32'd1;
          end
          state_o.size_or_remaining = state_i.size_or_remaining - 32'd1;
          if (state_i.size_or_remaining == 32'd1) begin
            state_o.phase = PH_SKIP_LINE;
          end
        end
        PH_SKIP_LINE: begin
          if (item_i.data_byte == CharLf) begin
            state_o.phase             = PH_SIZE_FIRST;
            state_o.size_or_remaining = '0;
            state_o.size_overflow     = 1'b0;
          end
        end
        PH_LAST_LINE: begin
          if (item_i.data_byte == CharLf) begin
            state_o.phase = PH_FINISHED;
            kind          = KIND_COMPLETE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign result_o.kind        = kind;
  assign result_o.body_byte   = byte_out;
  assign result_o.body_length = state_o.body_total;

endmodule

[rtl/core/chunked_body_decoder.sv]
// Top level of the chunked body decoder.
`timescale 1ns / 1ps
// Decodes a chunked message body at one byte per clock while the input is not stalled. Each accepted
// input beat gives exactly one result beat, which is held in the output register from the cycle after
// acceptance until it is taken. A new beat is taken in every cycle in which the input is not stalled;
// the input is stalled only while the output register holds a result that the downstream side is
// stalling. The decoder state and the result register are the only stages, so there is no start-up
// pass after reset. The chunk size limit is written through its own port, which is always ready.
module chunked_body_decoder
  import cbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] max_chunk_size_q;
  dec_state_t  state_q;
  dec_state_t  state_d;
  out_item_t   result_d;
  out_item_t   out_data_q;
  logic        out_valid_q;
  logic        accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;

  cbd_step u_step (
    .state_i          (state_q),
    .item_i           (in_data_i),
    .max_chunk_size_i (max_chunk_size_q),
    .state_o          (state_d),
    .result_o         (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chunk_size_q <= MaxChunkSizeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_chunk_size_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase             <= PH_SIZE_FIRST;
      state_q.size_or_remaining <= '0;
      state_q.size_overflow     <= 1'b0;
      state_q.body_total        <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/core/cbd_checker.sv]
// Port-level checks for the chunked body decoder, bound to its top level.
`timescale 1ns / 1ps
module cbd_checker
  import cbd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_item_t   out_data_o
);

  // A result beat that is stalled stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result beat withdrawn");

  // The input is only held back by a full, stalled output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // Every accepted input beat yields a result beat in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat gave no result");

  // A body byte always counts towards the body length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_BODY |-> out_data_o.body_length != '0)
    else $error("body byte with zero body length");

  // Only body beats carry a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_BODY |-> out_data_o.body_byte == 8'd0)
    else $error("non-body result carries a byte");

endmodule

bind chunked_body_decoder cbd_checker u_cbd_checker (.*);
